// ----- src/ctag_pkg.sv -----
// types and constants shared by the corner turn address generator
package ctag_pkg;

   localparam int CHANNELS_PER_PACKET = 4;
   localparam int POLARIZATIONS       = 4;

   localparam int TAB_W      = 4;
   localparam int GROUP_W    = 9;
   localparam int PACKET_W   = 6;
   localparam int CIG_W      = 2;
   localparam int POL_W      = 2;
   localparam int TABS_W     = 5;
   localparam int GROUPS_W   = 10;
   localparam int PACKETS_W  = 7;
   localparam int CHANS_W    = 12;
   localparam int ROW_W      = 17;
   localparam int ADDR_W     = 32;
   localparam int BYTE_W     = 8;

   localparam int MAX_TABS    = 16;
   localparam int MAX_GROUPS  = 512;
   localparam int MAX_PACKETS = 64;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_TAB_COUNT            = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PACKETS_PER_SEQUENCE = 2'd2;

   typedef struct packed {
      logic [TAB_W-1:0]    tab;
      logic [GROUP_W-1:0]  group;
      logic [PACKET_W-1:0] packet;
      logic [CIG_W-1:0]    cig;
      logic [POL_W-1:0]    pol;
   } ctag_pos_type;

   typedef struct packed {
      logic [TABS_W-1:0]    tabs;
      logic [GROUPS_W-1:0]  groups;
      logic [PACKETS_W-1:0] packets;
   } ctag_cfg_type;

endpackage

// ----- src/ctag_if.sv -----
// word channels of the corner turn address generator
interface ctag_req_if;
   import ctag_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] sample_byte;
   modport source (output valid, output sample_byte, input ready);
   modport sink (input valid, input sample_byte, output ready);
endinterface

interface ctag_rsp_if;
   import ctag_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] dest_address;
   logic [BYTE_W-1:0] data_byte;
   logic              page_last;
   modport source (output valid, output dest_address, output data_byte, output page_last,
                   input ready);
   modport sink (input valid, input dest_address, input data_byte, input page_last,
                 output ready);
endinterface

interface ctag_csr_if;
   import ctag_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/corner_turn_address_generator_core.sv -----
// corner turn scatter address generator top level
// Takes one byte of a ring-buffer page per cycle in source order (tab, channel
// group, packet, sample, channel in group, polarization) and returns one word
// per byte with its destination address in tab, channel, polarization, time
// order, the byte itself and a last-of-page flag. Throughput is one byte per
// clock while the result channel takes words; a byte passes the row and time
// offset register, then the row times page-stride multiply register, on its
// way to the result channel. Position counters advance on every accepted
// byte and wrap to zero after the last byte of a page. Configuration writes
// take effect for the next byte and must be made with the pipeline empty;
// there is no clearing pass after reset.
module corner_turn_address_generator_core #(
   parameter int SAMPLES_PER_PACKET = 500
) (
   input  logic       clock,
   input  logic       reset,
   ctag_req_if.sink   req_channel,
   ctag_rsp_if.source rsp_channel,
   ctag_csr_if.sink   csr_channel
);
   import ctag_pkg::*;

   localparam int TIME_W = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
   localparam int PS_W   = PACKETS_W + $clog2(SAMPLES_PER_PACKET + 1);

   ctag_cfg_type      cfg;
   logic [PS_W-1:0]   ps;
   ctag_pos_type      pos;
   logic [TIME_W-1:0] time_index;
   logic              counter_last;
   logic              accept, row_en, out_en;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;

   assign out_en = !rsp_valid_ff || rsp_channel.ready;
   assign row_en = !s1_valid_ff || out_en;
   assign accept = req_channel.valid && row_en;
   assign req_channel.ready = row_en;

   ctag_cfg #(
      .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET),
      .PS_W(PS_W)
   ) u_cfg (
      .clock(clock),
      .reset(reset),
      .csr(csr_channel),
      .cfg(cfg),
      .ps(ps)
   );

   ctag_counter #(
      .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET),
      .TIME_W(TIME_W)
   ) u_counter (
      .clock(clock),
      .reset(reset),
      .advance(accept),
      .cfg(cfg),
      .pos(pos),
      .time_index(time_index),
      .last(counter_last)
   );

   ctag_addr #(
      .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET),
      .TIME_W(TIME_W),
      .PS_W(PS_W)
   ) u_addr (
      .clock(clock),
      .load_row(accept),
      .load_addr(out_en && s1_valid_ff),
      .pos(pos),
      .time_index(time_index),
      .cfg(cfg),
      .ps(ps),
      .dest_address(rsp_channel.dest_address)
   );

   always_comb begin
      s1_valid_in  = row_en ? accept : s1_valid_ff;
      rsp_valid_in = out_en ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_channel.sample_byte;
         s1_last_ff <= counter_last;
      end
      if (out_en && s1_valid_ff) begin
         rsp_byte_ff <= s1_byte_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_channel.valid     = rsp_valid_ff;
   assign rsp_channel.data_byte = rsp_byte_ff;
   assign rsp_channel.page_last = rsp_last_ff;

   // polarization counter steps by one inside a channel
   a_pol_step: assert property (@(posedge clock) disable iff (reset)
      accept && pos.pol != POL_W'(POLARIZATIONS - 1) |=> pos.pol == $past(pos.pol) + POL_W'(1))
      else $error("polarization counter did not step");

   // last word of a page returns every counter to zero
   a_page_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && counter_last |=> pos == '0 && time_index == '0)
      else $error("counters not cleared after last word of page");

   // a result only appears after the row stage held a word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result valid without a word in the row stage");

endmodule

// ----- src/ctag_cfg.sv -----
// configuration registers with range clamping and page stride
module ctag_cfg #(
   parameter int SAMPLES_PER_PACKET = 500,
   parameter int PS_W               = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   ctag_csr_if.sink              csr,
   output ctag_pkg::ctag_cfg_type cfg,
   output logic [PS_W-1:0]       ps
);
   import ctag_pkg::*;

   ctag_cfg_type          cfg_ff, cfg_in;
   logic [PS_W-1:0]       ps_ff, ps_in;
   logic [TABS_W-1:0]     tabs_raw, tabs_clamp;
   logic [GROUPS_W-1:0]   groups_raw, groups_clamp;
   logic [PACKETS_W-1:0]  packets_raw, packets_clamp;

   assign csr.ready = 1'b1;

   always_comb begin
      tabs_raw    = csr.data[TABS_W-1:0];
      groups_raw  = csr.data[CSR_DATA_W-1:CSR_DATA_W-GROUPS_W];
      packets_raw = csr.data[PACKETS_W-1:0];

      if (tabs_raw == '0) tabs_clamp = TABS_W'(1);
      else if (tabs_raw > TABS_W'(MAX_TABS)) tabs_clamp = TABS_W'(MAX_TABS);
      else tabs_clamp = tabs_raw;

      if (groups_raw == '0) groups_clamp = GROUPS_W'(1);
      else if (groups_raw > GROUPS_W'(MAX_GROUPS)) groups_clamp = GROUPS_W'(MAX_GROUPS);
      else groups_clamp = groups_raw;

      if (packets_raw == '0) packets_clamp = PACKETS_W'(1);
      else if (packets_raw > PACKETS_W'(MAX_PACKETS)) packets_clamp = PACKETS_W'(MAX_PACKETS);
      else packets_clamp = packets_raw;

      cfg_in = cfg_ff;
      ps_in  = ps_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_TAB_COUNT: begin
               cfg_in.tabs = tabs_clamp;
            end
            CSR_CHANNEL_COUNT: begin
               cfg_in.groups = groups_clamp;
            end
            CSR_PACKETS_PER_SEQUENCE: begin
               cfg_in.packets = packets_clamp;
               ps_in = PS_W'(packets_clamp) * PS_W'(SAMPLES_PER_PACKET);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tabs    <= TABS_W'(1);
         cfg_ff.groups  <= GROUPS_W'(1);
         cfg_ff.packets <= PACKETS_W'(1);
         ps_ff          <= PS_W'(SAMPLES_PER_PACKET);
      end else begin
         cfg_ff <= cfg_in;
         ps_ff  <= ps_in;
      end
   end

   assign cfg = cfg_ff;
   assign ps  = ps_ff;

endmodule

// ----- src/ctag_counter.sv -----
// mixed-radix position counters in source order
module ctag_counter #(
   parameter int SAMPLES_PER_PACKET = 500,
   parameter int TIME_W             = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ctag_pkg::ctag_cfg_type cfg,
   output ctag_pkg::ctag_pos_type pos,
   output logic [TIME_W-1:0]      time_index,
   output logic                   last
);
   import ctag_pkg::*;

   ctag_pos_type      pos_ff, pos_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic pol_wrap, cig_wrap, time_wrap, packet_wrap, group_wrap, tab_wrap;
   logic c_cig, c_time, c_packet, c_group, c_tab;

   always_comb begin
      pol_wrap    = pos_ff.pol == POL_W'(POLARIZATIONS - 1);
      cig_wrap    = pos_ff.cig == CIG_W'(CHANNELS_PER_PACKET - 1);
      time_wrap   = ({1'b0, time_ff} + (TIME_W+1)'(1)) >= (TIME_W+1)'(SAMPLES_PER_PACKET);
      packet_wrap = ({1'b0, pos_ff.packet} + PACKETS_W'(1)) >= cfg.packets;
      group_wrap  = ({1'b0, pos_ff.group} + GROUPS_W'(1)) >= cfg.groups;
      tab_wrap    = ({1'b0, pos_ff.tab} + TABS_W'(1)) >= cfg.tabs;

      c_cig    = pol_wrap;
      c_time   = c_cig & cig_wrap;
      c_packet = c_time & time_wrap;
      c_group  = c_packet & packet_wrap;
      c_tab    = c_group & group_wrap;
      last     = c_tab & tab_wrap;

      pos_in  = pos_ff;
      time_in = time_ff;
      if (advance) begin
         pos_in.pol = pol_wrap ? '0 : pos_ff.pol + POL_W'(1);
         if (c_cig) pos_in.cig = cig_wrap ? '0 : pos_ff.cig + CIG_W'(1);
         if (c_time) time_in = time_wrap ? '0 : time_ff + TIME_W'(1);
         if (c_packet) pos_in.packet = packet_wrap ? '0 : pos_ff.packet + PACKET_W'(1);
         if (c_group) pos_in.group = group_wrap ? '0 : pos_ff.group + GROUP_W'(1);
         if (c_tab) pos_in.tab = tab_wrap ? '0 : pos_ff.tab + TAB_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         time_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         time_ff <= time_in;
      end
   end

   assign pos        = pos_ff;
   assign time_index = time_ff;

endmodule

// ----- src/ctag_addr.sv -----
// two-stage destination address datapath
module ctag_addr #(
   parameter int SAMPLES_PER_PACKET = 500,
   parameter int TIME_W             = 9,
   parameter int PS_W               = 16
) (
   input  logic                          clock,
   input  logic                          load_row,
   input  logic                          load_addr,
   input  ctag_pkg::ctag_pos_type        pos,
   input  logic [TIME_W-1:0]             time_index,
   input  ctag_pkg::ctag_cfg_type        cfg,
   input  logic [PS_W-1:0]               ps,
   output logic [ctag_pkg::ADDR_W-1:0]   dest_address
);
   import ctag_pkg::*;

   localparam int PROD_W = ROW_W + PS_W;

   logic [CHANS_W-1:0] chans;
   logic [ROW_W-1:0]   chan;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  off_ff, off_in;
   logic [PROD_W-1:0]  prod;
   logic [ADDR_W-1:0]  addr_ff, addr_in;

   always_comb begin
      chans  = CHANS_W'(cfg.groups * CHANNELS_PER_PACKET);
      chan   = ROW_W'(pos.tab) * ROW_W'(chans)
             + ROW_W'(pos.group) * ROW_W'(CHANNELS_PER_PACKET)
             + ROW_W'(pos.cig);
      row_in = chan * ROW_W'(POLARIZATIONS) + ROW_W'(pos.pol);
      off_in = ADDR_W'(pos.packet) * ADDR_W'(SAMPLES_PER_PACKET) + ADDR_W'(time_index);
      prod   = PROD_W'(row_ff) * PROD_W'(ps);
      addr_in = ADDR_W'(prod) + off_ff;
   end

   always_ff @(posedge clock) begin
      if (load_row) begin
         row_ff <= row_in;
         off_ff <= off_in;
      end
      if (load_addr) begin
         addr_ff <= addr_in;
      end
   end

   assign dest_address = addr_ff;

endmodule

// ----- dv/corner_turn_address_generator_core_test.sv -----
// self-checking testbench for the corner turn scatter address generator
module corner_turn_address_generator_core_test;
   import ctag_pkg::*;

   localparam int SAMPLES_PER_PACKET = 500;
   localparam int RESET_CYCLES = 6;
   localparam int PIPE_SLACK = 6;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int CYCLE_LIMIT = 6000000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] dest_address;
      logic [BYTE_W-1:0] data_byte;
      logic              page_last;
   } scatter_word_type;

   logic clock = 1'b0;
   logic reset;

   ctag_req_if req_channel();
   ctag_rsp_if rsp_channel();
   ctag_csr_if csr_channel();

   corner_turn_address_generator_core #(
      .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_channel(req_channel),
      .rsp_channel(rsp_channel),
      .csr_channel(csr_channel)
   );

   always #5 clock = ~clock;

   logic [TABS_W-1:0]    tab_reg;
   logic [CHANS_W-1:0]   chan_reg;
   logic [PACKETS_W-1:0] pkt_reg;
   int unsigned tab_pos, group_pos, packet_pos, sample_pos, cig_pos, pol_pos;

   scatter_word_type scatter_words_due[$];
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;
   bit               idling_on = 1'b1;
   bit               hold_off_armed = 1'b0;

   function automatic int unsigned tabs_in_use();
      if (tab_reg == 0) return 1;
      if (tab_reg > MAX_TABS) return MAX_TABS;
      return tab_reg;
   endfunction

   function automatic int unsigned groups_in_use();
      int unsigned g;
      g = chan_reg / CHANNELS_PER_PACKET;
      if (g == 0) return 1;
      if (g > MAX_GROUPS) return MAX_GROUPS;
      return g;
   endfunction

   function automatic int unsigned packets_in_use();
      if (pkt_reg == 0) return 1;
      if (pkt_reg > MAX_PACKETS) return MAX_PACKETS;
      return pkt_reg;
   endfunction

   function automatic bit step_counter(inout int unsigned ctr, input int unsigned limit);
      if (ctr + 1 >= limit) begin
         ctr = 0;
         return 1'b1;
      end
      ctr = ctr + 1;
      return 1'b0;
   endfunction

   function automatic scatter_word_type predict_scatter_word(input logic [BYTE_W-1:0] b);
      scatter_word_type w;
      longint unsigned  chans, pk, chan, row, addr;
      chans = longint'(groups_in_use()) * CHANNELS_PER_PACKET;
      pk = packets_in_use();
      chan = longint'(tab_pos) * chans + longint'(group_pos) * CHANNELS_PER_PACKET + cig_pos;
      row = chan * POLARIZATIONS + pol_pos;
      addr = row * pk * SAMPLES_PER_PACKET + longint'(packet_pos) * SAMPLES_PER_PACKET
             + sample_pos;
      w.dest_address = addr[ADDR_W-1:0];
      w.data_byte = b;
      w.page_last = 1'b0;
      if (step_counter(pol_pos, POLARIZATIONS))
         if (step_counter(cig_pos, CHANNELS_PER_PACKET))
            if (step_counter(sample_pos, SAMPLES_PER_PACKET))
               if (step_counter(packet_pos, packets_in_use()))
                  if (step_counter(group_pos, groups_in_use()))
                     if (step_counter(tab_pos, tabs_in_use()))
                        w.page_last = 1'b1;
      return w;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_register_value(input int unsigned low,
                                                                 input int unsigned high);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return CSR_DATA_W'($urandom_range(0, (1 << CSR_DATA_W) - 1));
      if (r < 22) return CSR_DATA_W'(low);
      if (r < 34) return CSR_DATA_W'(high);
      if (r < 38) return '0;
      return CSR_DATA_W'($urandom_range(low, high));
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, output bit page_end);
      int unsigned      gap;
      scatter_word_type w;
      gap = pick_gap();
      if (gap > 0) begin
         req_channel.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_channel.valid <= 1'b1;
      req_channel.sample_byte <= b;
      do @(posedge clock); while (!req_channel.ready);
      w = predict_scatter_word(b);
      scatter_words_due.push_back(w);
      page_end = w.page_last;
   endtask

   task automatic send_random_bytes(input int unsigned count);
      bit page_end;
      repeat (count) send_byte(BYTE_W'($urandom_range(0, 255)), page_end);
   endtask

   task automatic wait_until_drained();
      req_channel.valid <= 1'b0;
      while (scatter_words_due.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value, input bit lower_after);
      csr_channel.valid <= 1'b1;
      csr_channel.index <= index;
      csr_channel.data <= value;
      do @(posedge clock); while (!csr_channel.ready);
      if (lower_after) csr_channel.valid <= 1'b0;
      case (index)
         CSR_TAB_COUNT: tab_reg = value[TABS_W-1:0];
         CSR_CHANNEL_COUNT: chan_reg = value[CHANS_W-1:0];
         CSR_PACKETS_PER_SEQUENCE: pkt_reg = value[PACKETS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] tabs,
                               input logic [CSR_DATA_W-1:0] chans,
                               input logic [CSR_DATA_W-1:0] pkts);
      write_register(CSR_TAB_COUNT, tabs, 1'b0);
      write_register(CSR_CHANNEL_COUNT, chans, 1'b0);
      write_register(CSR_PACKETS_PER_SEQUENCE, pkts, 1'b1);
   endtask

   task automatic test_byte_passthrough();
      logic [BYTE_W-1:0] bytes_in[6];
      bit                page_end;
      bytes_in = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
      foreach (bytes_in[i]) send_byte(bytes_in[i], page_end);
      wait_until_drained();
   endtask

   task automatic test_register_limits();
      logic [CSR_DATA_W-1:0] settings[5][3];
      settings = '{'{12'h000, 12'h000, 12'h000},
                   '{12'h010, 12'h800, 12'h040},
                   '{12'hFFF, 12'hFFF, 12'hFFF},
                   '{12'h011, 12'h003, 12'h041},
                   '{12'h001, 12'h005, 12'h001}};
      write_register(CSR_UNUSED_INDEX, 12'hA5A, 1'b0);
      foreach (settings[i]) begin
         write_config(settings[i][0], settings[i][1], settings[i][2]);
         send_random_bytes(2);
         wait_until_drained();
      end
   endtask

   // change the packet and channel counts partway through a page, counters keep their place
   task automatic test_mid_page_write();
      write_config(12'd2, 12'd8, 12'd2);
      send_random_bytes(300);
      wait_until_drained();
      write_register(CSR_PACKETS_PER_SEQUENCE, 12'd1, 1'b1);
      send_random_bytes(160);
      wait_until_drained();
      write_register(CSR_CHANNEL_COUNT, 12'd4, 1'b1);
      send_random_bytes(160);
      wait_until_drained();
   endtask

   task automatic test_output_backpressure();
      idling_on = 1'b0;
      hold_off_armed = 1'b1;
      send_random_bytes(64);
      wait_until_drained();
      idling_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      repeat (4) begin
         write_config(pick_register_value(1, MAX_TABS),
                      pick_register_value(4, MAX_GROUPS * CHANNELS_PER_PACKET),
                      pick_register_value(1, MAX_PACKETS));
         idling_on = ($urandom_range(0, 3) != 0);
         send_random_bytes($urandom_range(90, 130));
         wait_until_drained();
      end
      idling_on = 1'b1;
   endtask

   initial begin : rsp_ready_driver
      int unsigned n;
      rsp_channel.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            rsp_channel.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_channel.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_channel.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_scatter_words
      scatter_word_type seen, want;
      if (!reset && rsp_channel.valid && rsp_channel.ready) begin
         seen.dest_address = rsp_channel.dest_address;
         seen.data_byte = rsp_channel.data_byte;
         seen.page_last = rsp_channel.page_last;
         if (scatter_words_due.size() == 0) begin
            $display("%0t: unexpected word, address %h byte %h last %b",
                     $time, seen.dest_address, seen.data_byte, seen.page_last);
            mismatch_count++;
         end else begin
            want = scatter_words_due.pop_front();
            if (seen.dest_address !== want.dest_address) begin
               $display("%0t: dest_address expected %h got %h",
                        $time, want.dest_address, seen.dest_address);
               mismatch_count++;
            end
            if (seen.data_byte !== want.data_byte) begin
               $display("%0t: data_byte expected %h got %h",
                        $time, want.data_byte, seen.data_byte);
               mismatch_count++;
            end
            if (seen.page_last !== want.page_last) begin
               $display("%0t: page_last expected %b got %b",
                        $time, want.page_last, seen.page_last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, scatter_words_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_channel.valid <= 1'b0;
      req_channel.sample_byte <= '0;
      csr_channel.valid <= 1'b0;
      csr_channel.index <= CSR_TAB_COUNT;
      csr_channel.data <= '0;
      tab_reg = 5'd1;
      chan_reg = 12'd4;
      pkt_reg = 7'd1;
      {tab_pos, group_pos, packet_pos, sample_pos, cig_pos, pol_pos} = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_byte_passthrough();
      test_register_limits();
      test_mid_page_write();
      test_output_backpressure();
      test_random_traffic();
      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
